FILE: rtl/core/fdr_pkg.sv
package fdr_pkg;

    // fraction bits of the reflectance and of the amplitude ratios
    localparam int FRAC_BITS = 15;

    // field and register widths
    localparam int CW        = 16;
    localparam int EW        = 16;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 1;

    // incident cosine is Q2.14, so sin^2 is Q.28
    localparam int SIN2_FRAC = 28;
    localparam int SQ_W      = SIN2_FRAC + 1;
    localparam int E2_W      = 2 * EW;
    localparam int LHS_W     = E2_W + SQ_W;
    localparam int NUM_W     = LHS_W + 1;

    // transmitted cos^2 in Q.30 and its root in Q.15, both reaching 1.0
    localparam int CT2_W     = 31;
    localparam int CT_W      = (CT2_W + 1) / 2;
    localparam int ISQ_W     = CT2_W + 1;

    // amplitude ratio datapath
    localparam int CI_W      = CW + 1;
    localparam int PQ_W      = 36;
    localparam int RQ_W      = FRAC_BITS + 2;
    localparam int RREM_W    = PQ_W + RQ_W;
    localparam int RSQ_W     = 2 * RQ_W;
    localparam int SUMSH_W   = RSQ_W + 1 - (FRAC_BITS + 1);

    // pipeline depth from accepted item to result strobe
    localparam int LATENCY   = 4 + CT2_W + CT_W + 5 + RQ_W;

    localparam logic [2*CW-1:0]   SIN2_ONE  = (2*CW)'(64'd1 << SIN2_FRAC);
    localparam logic [RQ_W-1:0]   RATIO_LIM = RQ_W'(64'd1 << (FRAC_BITS + 1));
    localparam logic [SUMSH_W-1:0] REFL_ONE = SUMSH_W'(64'd1 << FRAC_BITS);
    localparam logic [OUT_W-1:0]  OUT_ONE   = OUT_W'(64'd1 << FRAC_BITS);

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_ETA_OUTSIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_INSIDE  = 1'b1;
    localparam logic [EW-1:0] ETA_OUTSIDE_RST = 16'd4096;
    localparam logic [EW-1:0] ETA_INSIDE_RST  = 16'd6144;

    typedef struct packed {
        logic [EW-1:0] eta_outside;
        logic [EW-1:0] eta_inside;
    } t_eta;

    typedef struct packed {
        logic                 tir;
        logic signed [CW-1:0] c;
        logic [NUM_W-1:0]     num;
        logic [E2_W-1:0]      den;
    } t_ct2_job;

    typedef struct packed {
        logic                 tir;
        logic signed [CW-1:0] c;
        logic [CT2_W-1:0]     ct2;
    } t_sqrt_job;

    typedef struct packed {
        logic                 tir;
        logic signed [CW-1:0] c;
        logic [CT_W-1:0]      ct;
    } t_ratio_job;

endpackage

FILE: rtl/core/fdr_front.sv
module fdr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [fdr_pkg::CW-1:0]  i_cos,
    input  fdr_pkg::t_eta                  i_eta,
    output logic                           o_valid,
    output fdr_pkg::t_ct2_job              o_job
);

    logic                                r1_v, r2_v, r3_v, r4_v;
    logic signed [fdr_pkg::CW-1:0]       r1_c, r2_c, r3_c;
    logic [fdr_pkg::SQ_W-1:0]            r2_si2;
    logic [fdr_pkg::E2_W-1:0]            r2_ea2, r2_eb2, r3_eb2;
    logic                                r2_ebz, r3_ebz;
    logic [fdr_pkg::LHS_W-1:0]           r3_lhs;
    fdr_pkg::t_ct2_job                   r4_job;

    logic signed [2*fdr_pkg::CW-1:0]     c2;
    logic [2*fdr_pkg::CW-1:0]            c2u;
    logic [fdr_pkg::SQ_W-1:0]            n_si2;
    logic [fdr_pkg::LHS_W-1:0]           rhs, diff;
    fdr_pkg::t_ct2_job                   n_job;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // incident sin^2 in Q.28, clamped at zero
    always_comb begin
        c2    = r1_c * r1_c;
        c2u   = $unsigned(c2);
        n_si2 = (c2u >= fdr_pkg::SIN2_ONE) ? '0 : fdr_pkg::SQ_W'(fdr_pkg::SIN2_ONE - c2u);
    end

    // total reflection test and numerator of cos^2 of the transmitted angle
    always_comb begin
        rhs       = fdr_pkg::LHS_W'({r3_eb2, {fdr_pkg::SIN2_FRAC{1'b0}}});
        diff      = rhs - r3_lhs;
        n_job.tir = r3_ebz || (r3_lhs >= rhs);
        n_job.c   = r3_c;
        n_job.num = fdr_pkg::NUM_W'({diff, 2'b00});
        n_job.den = r3_eb2;
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r1_c   <= i_cos;
        r2_c   <= r1_c;
        r2_si2 <= n_si2;
        r2_ea2 <= i_eta.eta_outside * i_eta.eta_outside;
        r2_eb2 <= i_eta.eta_inside * i_eta.eta_inside;
        r2_ebz <= (i_eta.eta_inside == '0);
        r3_c   <= r2_c;
        r3_lhs <= r2_ea2 * r2_si2;
        r3_eb2 <= r2_eb2;
        r3_ebz <= r2_ebz;
        r4_job <= n_job;
    end

    assign o_valid = r4_v;
    assign o_job   = r4_job;

endmodule

FILE: rtl/core/fdr_ct_div.sv
module fdr_ct_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  fdr_pkg::t_ct2_job  i_job,
    output logic               o_valid,
    output fdr_pkg::t_sqrt_job o_job
);

    localparam int N = fdr_pkg::CT2_W;

    logic                    r_v   [N];
    fdr_pkg::t_ct2_job       r_job [N];
    logic [N-1:0]            r_q   [N];

    // restoring divider, one quotient bit per stage, msb first
    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam int SH = N - 1 - s;
        logic                    v_in;
        fdr_pkg::t_ct2_job       job_in;
        logic [N-1:0]            q_in;
        logic [fdr_pkg::NUM_W-1:0] trial;
        logic                    ge;
        fdr_pkg::t_ct2_job       n_job;

        if (s == 0) begin : g_first
            assign v_in   = i_valid;
            assign job_in = i_job;
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = r_v[s-1];
            assign job_in = r_job[s-1];
            assign q_in   = r_q[s-1];
        end

        always_comb begin
            trial     = fdr_pkg::NUM_W'(job_in.den) << SH;
            ge        = (job_in.num >= trial);
            n_job     = job_in;
            n_job.num = ge ? job_in.num - trial : job_in.num;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_job[s] <= n_job;
            r_q[s]   <= {q_in[N-2:0], ge};
        end
    end

    assign o_valid   = r_v[N-1];
    assign o_job.tir = r_job[N-1].tir;
    assign o_job.c   = r_job[N-1].c;
    assign o_job.ct2 = r_q[N-1];

endmodule

FILE: rtl/core/fdr_sqrt.sv
module fdr_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  fdr_pkg::t_sqrt_job  i_job,
    output logic                o_valid,
    output fdr_pkg::t_ratio_job o_job
);

    localparam int N = fdr_pkg::CT_W;
    localparam int W = fdr_pkg::ISQ_W;

    logic                          r_v   [N];
    logic                          r_tir [N];
    logic signed [fdr_pkg::CW-1:0] r_c   [N];
    logic [W-1:0]                  r_rem [N];
    logic [W-1:0]                  r_res [N];

    // digit by digit integer root, one result bit per stage
    for (genvar s = 0; s < N; s++) begin : g_stage
        localparam int K = N - 1 - s;
        localparam logic [W-1:0] BIT = W'(64'd1 << (2 * K));
        logic                          v_in, tir_in;
        logic signed [fdr_pkg::CW-1:0] c_in;
        logic [W-1:0]                  rem_in, res_in, trial;
        logic                          ge;

        if (s == 0) begin : g_first
            assign v_in   = i_valid;
            assign tir_in = i_job.tir;
            assign c_in   = i_job.c;
            assign rem_in = W'(i_job.ct2);
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[s-1];
            assign tir_in = r_tir[s-1];
            assign c_in   = r_c[s-1];
            assign rem_in = r_rem[s-1];
            assign res_in = r_res[s-1];
        end

        always_comb begin
            trial = res_in + BIT;
            ge    = (rem_in >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_tir[s] <= tir_in;
            r_c[s]   <= c_in;
            r_rem[s] <= ge ? rem_in - trial : rem_in;
            r_res[s] <= ge ? (res_in >> 1) + BIT : (res_in >> 1);
        end
    end

    assign o_valid   = r_v[N-1];
    assign o_job.tir = r_tir[N-1];
    assign o_job.c   = r_c[N-1];
    assign o_job.ct  = r_res[N-1][fdr_pkg::CT_W-1:0];

endmodule

FILE: rtl/core/fdr_ratio.sv
module fdr_ratio (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  fdr_pkg::t_ratio_job             i_job,
    input  fdr_pkg::t_eta                   i_eta,
    output logic                            o_valid,
    output logic [fdr_pkg::OUT_W-1:0]       o_reflectance,
    output logic                            o_total_internal
);

    localparam int N  = fdr_pkg::RQ_W;
    localparam int RW = fdr_pkg::RREM_W;
    localparam int PW = fdr_pkg::PQ_W;
    localparam int MW = fdr_pkg::EW + fdr_pkg::CI_W + 1;
    localparam int UW = fdr_pkg::EW + fdr_pkg::CT_W;

    // stage a: products
    logic                  ra_v, ra_tir;
    logic signed [MW-1:0]  ra_eb_ci, ra_ea_ci;
    logic [UW-1:0]         ra_ea_ct, ra_eb_ct;
    // stage b: magnitudes
    logic                  rb_v, rb_tir, rb_qz;
    logic [PW-1:0]         rb_a [2];
    logic [PW-1:0]         rb_b [2];
    // stage c and divider
    logic                  rc_v, rc_tir, rc_qz;
    logic [RW-1:0]         rc_rem [2];
    logic [PW-1:0]         rc_den [2];
    logic                  rc_big [2];
    logic                  rd_v   [N];
    logic                  rd_tir [N];
    logic                  rd_qz  [N];
    logic [1:0][RW-1:0]    rd_rem [N];
    logic [1:0][PW-1:0]    rd_den [N];
    logic [1:0]            rd_big [N];
    logic [1:0][N-1:0]     rd_q   [N];
    // squares and output
    logic                  rs_v, rs_tir, rs_qz;
    logic [fdr_pkg::RSQ_W-1:0] rs_sq [2];
    logic                  r_out_v, r_out_tir;
    logic [fdr_pkg::OUT_W-1:0] r_out_refl;

    logic signed [fdr_pkg::CI_W-1:0] ci;
    logic signed [fdr_pkg::EW:0]     ea_s, eb_s;
    logic signed [PW-1:0]            p1, q1, p2, q2;
    logic [N-1:0]                    rt [2];
    logic [fdr_pkg::RSQ_W:0]         sum;
    logic [fdr_pkg::SUMSH_W-1:0]     sum_sh, refl;

    // control valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v    <= 1'b0;
            rb_v    <= 1'b0;
            rc_v    <= 1'b0;
            rs_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            ra_v    <= i_valid;
            rb_v    <= ra_v;
            rc_v    <= rb_v;
            rs_v    <= rd_v[N-1];
            r_out_v <= rs_v;
        end
    end

    // cross products of the indices with both cosines
    always_comb begin
        ci   = fdr_pkg::CI_W'(i_job.c) <<< 1;
        ea_s = $signed({1'b0, i_eta.eta_outside});
        eb_s = $signed({1'b0, i_eta.eta_inside});
    end

    always_ff @(posedge i_clk) begin
        ra_tir   <= i_job.tir;
        ra_eb_ci <= MW'(eb_s * ci);
        ra_ea_ci <= MW'(ea_s * ci);
        ra_ea_ct <= i_eta.eta_outside * i_job.ct;
        ra_eb_ct <= i_eta.eta_inside * i_job.ct;
    end

    // numerators and denominators of both amplitude ratios
    always_comb begin
        p1 = PW'(ra_eb_ci) - $signed({{(PW-UW){1'b0}}, ra_ea_ct});
        q1 = PW'(ra_eb_ci) + $signed({{(PW-UW){1'b0}}, ra_ea_ct});
        p2 = PW'(ra_ea_ci) - $signed({{(PW-UW){1'b0}}, ra_eb_ct});
        q2 = PW'(ra_ea_ci) + $signed({{(PW-UW){1'b0}}, ra_eb_ct});
    end

    always_ff @(posedge i_clk) begin
        rb_tir  <= ra_tir;
        rb_qz   <= (q1 == '0) || (q2 == '0);
        rb_a[0] <= p1[PW-1] ? $unsigned(-p1) : $unsigned(p1);
        rb_b[0] <= q1[PW-1] ? $unsigned(-q1) : $unsigned(q1);
        rb_a[1] <= p2[PW-1] ? $unsigned(-p2) : $unsigned(p2);
        rb_b[1] <= q2[PW-1] ? $unsigned(-q2) : $unsigned(q2);
    end

    // scaled dividend and the test for a quotient past the divider's range
    always_ff @(posedge i_clk) begin
        rc_tir <= rb_tir;
        rc_qz  <= rb_qz;
        for (int k = 0; k < 2; k++) begin
            rc_rem[k] <= RW'(rb_a[k]) << fdr_pkg::FRAC_BITS;
            rc_den[k] <= rb_b[k];
            rc_big[k] <= (RW'(rb_a[k]) << fdr_pkg::FRAC_BITS) >= (RW'(rb_b[k]) << N);
        end
    end

    // two restoring dividers side by side, one quotient bit per stage
    for (genvar s = 0; s < N; s++) begin : g_div
        localparam int SH = N - 1 - s;
        logic               v_in, tir_in, qz_in;
        logic [1:0][RW-1:0] rem_in, n_rem;
        logic [1:0][PW-1:0] den_in;
        logic [1:0]         big_in, ge;
        logic [1:0][N-1:0]  q_in, n_q;
        logic [RW-1:0]      trial;

        if (s == 0) begin : g_first
            assign v_in   = rc_v;
            assign tir_in = rc_tir;
            assign qz_in  = rc_qz;
            assign rem_in = {rc_rem[1], rc_rem[0]};
            assign den_in = {rc_den[1], rc_den[0]};
            assign big_in = {rc_big[1], rc_big[0]};
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = rd_v[s-1];
            assign tir_in = rd_tir[s-1];
            assign qz_in  = rd_qz[s-1];
            assign rem_in = rd_rem[s-1];
            assign den_in = rd_den[s-1];
            assign big_in = rd_big[s-1];
            assign q_in   = rd_q[s-1];
        end

        always_comb begin
            trial = '0;
            for (int k = 0; k < 2; k++) begin
                trial    = RW'(den_in[k]) << SH;
                ge[k]    = (rem_in[k] >= trial);
                n_rem[k] = ge[k] ? rem_in[k] - trial : rem_in[k];
                n_q[k]   = {q_in[k][N-2:0], ge[k]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rd_v[s] <= 1'b0;
            end else begin
                rd_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            rd_tir[s] <= tir_in;
            rd_qz[s]  <= qz_in;
            rd_rem[s] <= n_rem;
            rd_den[s] <= den_in;
            rd_big[s] <= big_in;
            rd_q[s]   <= n_q;
        end
    end

    // clamp each ratio at 2.0 and square it
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (rd_big[N-1][k] || (rd_q[N-1][k] > fdr_pkg::RATIO_LIM)) begin
                rt[k] = fdr_pkg::RATIO_LIM;
            end else begin
                rt[k] = rd_q[N-1][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        rs_tir   <= rd_tir[N-1];
        rs_qz    <= rd_qz[N-1];
        rs_sq[0] <= rt[0] * rt[0];
        rs_sq[1] <= rt[1] * rt[1];
    end

    // mean of the squares, saturated at 1.0
    always_comb begin
        sum    = {1'b0, rs_sq[0]} + {1'b0, rs_sq[1]};
        sum_sh = fdr_pkg::SUMSH_W'(sum >> (fdr_pkg::FRAC_BITS + 1));
        refl   = (sum_sh > fdr_pkg::REFL_ONE) ? fdr_pkg::REFL_ONE : sum_sh;
    end

    always_ff @(posedge i_clk) begin
        r_out_tir  <= rs_tir;
        r_out_refl <= (rs_tir || rs_qz) ? fdr_pkg::OUT_ONE : fdr_pkg::OUT_W'(refl);
    end

    assign o_valid          = r_out_v;
    assign o_reflectance    = r_out_refl;
    assign o_total_internal = r_out_tir;

endmodule

FILE: rtl/core/fresnel_dielectric_reflectance.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+-------------------------------------
// item in   | input     | start, busy           | i_cos_incident (Q2.14 signed)
// result    | output    | o_valid (strobe)      | o_reflectance (Q1.15), o_total_internal
// config    | input     | i_cfg_we, i_cfg_idx   | i_cfg_wdata (index 0 outside, 1 inside)
//
// one item enters per cycle while busy is low; each result strobes after its transfer
// has passed the 31-stage divider for cos^2, the 16-stage root and the 17-stage ratio dividers
// busy is high only during reset; synchronous reset clears the valid bits and
// loads the indices with 1.0 and 1.5; results cannot be held off by the receiver
module fresnel_dielectric_reflectance (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fdr_pkg::CW-1:0]       i_cos_incident,
    input  logic                                i_cfg_we,
    input  logic [fdr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fdr_pkg::EW-1:0]              i_cfg_wdata,
    output logic                                o_valid,
    output logic [fdr_pkg::OUT_W-1:0]           o_reflectance,
    output logic                                o_total_internal
);

    fdr_pkg::t_eta       r_eta;
    logic                front_v, div_v, sqrt_v;
    fdr_pkg::t_ct2_job   front_job;
    fdr_pkg::t_sqrt_job  div_job;
    fdr_pkg::t_ratio_job sqrt_job;

    assign busy = ~i_rst_n;

    // index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta.eta_outside <= fdr_pkg::ETA_OUTSIDE_RST;
            r_eta.eta_inside  <= fdr_pkg::ETA_INSIDE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fdr_pkg::REG_ETA_OUTSIDE: r_eta.eta_outside <= i_cfg_wdata;
                fdr_pkg::REG_ETA_INSIDE:  r_eta.eta_inside  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sin^2, snell test and cos^2 numerator
    fdr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_cos   (i_cos_incident),
        .i_eta   (r_eta),
        .o_valid (front_v),
        .o_job   (front_job)
    );

    // cos^2 of the transmitted angle
    fdr_ct_div u_ct_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_v),
        .i_job   (front_job),
        .o_valid (div_v),
        .o_job   (div_job)
    );

    // transmitted cosine
    fdr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_v),
        .i_job   (div_job),
        .o_valid (sqrt_v),
        .o_job   (sqrt_job)
    );

    // amplitude ratios and their mean square
    fdr_ratio u_ratio (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (sqrt_v),
        .i_job            (sqrt_job),
        .i_eta            (r_eta),
        .o_valid          (o_valid),
        .o_reflectance    (o_reflectance),
        .o_total_internal (o_total_internal)
    );

endmodule

FILE: rtl/core/fdr_checker.sv
module fdr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [fdr_pkg::OUT_W-1:0]     o_reflectance,
    input logic                          o_total_internal
);

    // every result traces back to a transfer a fixed depth earlier
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, fdr_pkg::LATENCY))
        else $error("result strobe without a matching transfer");

    // total reflection always reports full reflectance
    a_tir_is_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_total_internal) |-> (o_reflectance == fdr_pkg::OUT_ONE))
        else $error("total reflection with reflectance below one");

    // reflectance never passes 1.0
    a_refl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reflectance <= fdr_pkg::OUT_ONE))
        else $error("reflectance above one");

    // no result leaves in the first cycle after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind fresnel_dielectric_reflectance fdr_checker u_fdr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_reflectance    (o_reflectance),
    .o_total_internal (o_total_internal)
);

FILE: sim/testbench.sv
module testbench;
    import fdr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1500;

    // reflectance predictor and queue of pending results
    class fresnel_scoreboard;
        logic [EW-1:0]    eta_out;
        logic [EW-1:0]    eta_in;
        logic [OUT_W-1:0] pend_refl[$];
        logic             pend_tir[$];
        int               n_err;

        function void reset_regs();
            eta_out = ETA_OUTSIDE_RST;
            eta_in  = ETA_INSIDE_RST;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [EW-1:0] val);
            if (idx == REG_ETA_OUTSIDE) eta_out = val;
            else eta_in = val;
        endfunction

        static function longint unsigned int_root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        static function longint unsigned amp_ratio(longint p, longint q);
            longint unsigned ap, aq, r;
            ap = p < 0 ? -p : p;
            aq = q < 0 ? -q : q;
            r = (ap << FRAC_BITS) / aq;
            if (r > (64'd1 << (FRAC_BITS + 1))) r = 64'd1 << (FRAC_BITS + 1);
            return r;
        endfunction

        // note an accepted item
        function void note_item(logic signed [CW-1:0] cos_i);
            longint c, ci, ea, eb, ct, p1, q1, p2, q2;
            longint unsigned c2, si2, lhs, rhs, eb2, r1, r2, refl;
            c = cos_i;
            c2 = c * c;
            si2 = (c2 >= (64'd1 << 28)) ? 0 : (64'd1 << 28) - c2;
            eb2 = longint'(eta_in) * eta_in;
            lhs = longint'(eta_out) * eta_out * si2;
            rhs = eb2 << 28;
            if (eta_in == 0 || lhs >= rhs) begin
                pend_refl.push_back(OUT_W'(64'd1 << FRAC_BITS));
                pend_tir.push_back(1'b1);
                return;
            end
            ct = int_root(((rhs - lhs) << 2) / eb2);
            ci = c * 2;
            ea = eta_out;
            eb = eta_in;
            p1 = eb * ci - ea * ct;
            q1 = eb * ci + ea * ct;
            p2 = ea * ci - eb * ct;
            q2 = ea * ci + eb * ct;
            if (q1 == 0 || q2 == 0) begin
                refl = 64'd1 << FRAC_BITS;
            end else begin
                r1 = amp_ratio(p1, q1);
                r2 = amp_ratio(p2, q2);
                refl = (r1 * r1 + r2 * r2) >> (FRAC_BITS + 1);
                if (refl > (64'd1 << FRAC_BITS)) refl = 64'd1 << FRAC_BITS;
            end
            pend_refl.push_back(OUT_W'(refl));
            pend_tir.push_back(1'b0);
        endfunction

        // compare one result with the oldest pending one
        function void check_result(logic [OUT_W-1:0] refl, logic tir);
            logic [OUT_W-1:0] exp_refl;
            logic             exp_tir;
            if (pend_refl.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result refl=%0d tir=%0b", refl, tir);
                return;
            end
            exp_refl = pend_refl.pop_front();
            exp_tir  = pend_tir.pop_front();
            if (refl !== exp_refl || tir !== exp_tir) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: expected refl=%0d tir=%0b, got refl=%0d tir=%0b",
                             exp_refl, exp_tir, refl, tir);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic signed [CW-1:0] i_cos_incident = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [EW-1:0]        i_cfg_wdata = '0;
    logic                 o_valid;
    logic [OUT_W-1:0]     o_reflectance;
    logic                 o_total_internal;

    fresnel_scoreboard sb = new();

    fresnel_dielectric_reflectance u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cos_incident   (i_cos_incident),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_reflectance    (o_reflectance),
        .o_total_internal (o_total_internal)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_reflectance, o_total_internal);
    end

    // mostly short idle gaps, a few long ones
    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one item transfer; start stays high when back to back
    task automatic send_item(logic signed [CW-1:0] cos_i, bit allow_gap);
        int gap;
        gap = allow_gap ? idle_len() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cos_incident <= cos_i;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(cos_i);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pend_refl.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // one register write; the write enable is then dropped before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] rand_cos();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7) return CW'($urandom_range(0, 32768) - 16384);
        if (k < 9) return CW'($urandom_range(0, 65535));
        return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    endfunction

    initial begin
        logic signed [CW-1:0] directed[$];
        logic [EW-1:0] eta_sets[$];
        sb.n_err = 0;
        sb.reset_regs();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, normal and grazing incidence, negative and out-of-range cosines
        directed = '{16'sd16384, 16'sd0, -16'sd16384, 16'sd1, -16'sd1, 16'sd8192,
                     -16'sd8192, 16'sd32767, -16'sd32768, 16'sd16385, -16'sd16385,
                     16'sd11585, 16'sh5555, -16'sh2aab, 16'sd100};
        foreach (directed[i]) send_item(directed[i], 1'b0);
        drain();

        // glass to air gives total reflection at shallow angles
        write_reg(REG_ETA_OUTSIDE, 16'd6144);
        write_reg(REG_ETA_INSIDE, 16'd4096);
        foreach (directed[i]) send_item(directed[i], 1'b1);
        drain();

        // zero inside index, then equal indices
        write_reg(REG_ETA_INSIDE, 16'd0);
        send_item(16'sd16384, 1'b0);
        send_item(16'sd0, 1'b0);
        drain();
        write_reg(REG_ETA_INSIDE, 16'd6144);
        write_reg(REG_ETA_OUTSIDE, 16'd6144);
        send_item(16'sd0, 1'b0);
        send_item(-16'sd16384, 1'b0);
        drain();

        // random phases over index settings including the extremes
        eta_sets = '{16'd1, 16'd65535, 16'd65535, 16'd1, 16'd4096, 16'd6144,
                     16'd1, 16'd1, 16'd65535, 16'd65535};
        for (int ph = 0; ph < 10; ph++) begin
            if (ph < 5) begin
                write_reg(REG_ETA_OUTSIDE, eta_sets[2*ph]);
                write_reg(REG_ETA_INSIDE, eta_sets[2*ph+1]);
            end else begin
                write_reg(REG_ETA_OUTSIDE, EW'($urandom_range(1, 65535)));
                write_reg(REG_ETA_INSIDE,
                          $urandom_range(0, 3) == 0 ? EW'($urandom_range(1, 65535))
                                                    : EW'($urandom_range(2048, 12288)));
            end
            for (int n = 0; n < N_RANDOM / 10; n++) send_item(rand_cos(), 1'b1);
            drain();
        end

        if (sb.n_err == 0 && sb.pend_refl.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
